FILE: rtl/core/gdr_pkg.sv
// gdr_pkg: shared types, constants and calendar helpers for the date register
`default_nettype none

package gdr_pkg;

  // operation codes carried by each input item
  typedef enum logic [1:0] {
    OP_NEXT_DAY   = 2'd0,
    OP_ADD_MONTHS = 2'd1,
    OP_COMPARE    = 2'd2,
    OP_LOAD       = 2'd3
  } gdr_op_e;

  // field widths
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DeltaW = 12;
  // year with headroom for a carry or a month offset
  localparam int unsigned YearXW = YearW + 1;
  // signed quotient of the month delta by twelve
  localparam int unsigned DqW    = 10;

  // reset date
  localparam logic [DayW-1:0]   ResetDay   = 5'd1;
  localparam logic [MonthW-1:0] ResetMonth = 4'd1;
  localparam logic [YearW-1:0]  ResetYear  = 14'd2000;
  localparam logic              ResetLeap  = 1'b1;

  // month numbers
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam int unsigned       MonthsPerYear = 12;

  // month delta split: offset keeps the dividend positive, reciprocal of 12
  localparam int unsigned DeltaOffsetYears = 171;
  localparam logic [12:0] DeltaOffset = 13'(DeltaOffsetYears * MonthsPerYear);
  localparam logic [12:0] Recip12     = 13'd5462;  // ceil(2^16 / 12)
  localparam int unsigned Recip12Shift = 16;

  // century test: reciprocal of 100
  localparam logic [15:0] Recip100 = 16'd41944;    // ceil(2^22 / 100)
  localparam int unsigned Recip100Shift = 22;

  // decoded item held in the input register
  typedef struct packed {
    gdr_op_e                  op;
    logic signed [DqW-1:0]    dq;
    logic [3:0]               dr;
    logic [DayW-1:0]          ld_day;
    logic [MonthW-1:0]        ld_month;
    logic                     ld_leap;
    logic                     ld_err;
    logic [DayW-1:0]          cmp_day;
    logic [MonthW-1:0]        cmp_month;
    logic [YearW-1:0]         cmp_year;
  } gdr_item_t;

  // leap rule: divisible by 4, centuries only when divisible by 400
  function automatic logic gdr_is_leap(input logic [YearXW-1:0] y);
    logic [29:0] prod;
    logic [7:0]  cent;
    logic [15:0] back;
    logic        is_cent;
    prod    = 30'(y) * 30'(Recip100);
    cent    = prod[Recip100Shift +: 8];
    back    = 16'(cent) * 16'd100;
    is_cent = (back == 16'(y));
    return is_cent ? (cent[1:0] == 2'b00) : (y[1:0] == 2'b00);
  endfunction

  // days in a month, month assumed 1..12
  function automatic logic [DayW-1:0] gdr_month_len(input logic [MonthW-1:0] m,
                                                    input logic leap);
    logic [DayW-1:0] len;
    if (m == MonthFeb) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gdr_if.sv
// gdr_in_if and gdr_out_if: valid/ready channels of the date register
`default_nettype none

interface gdr_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          opcode;
  logic signed [gdr_pkg::DeltaW-1:0]   month_delta;
  logic [gdr_pkg::DayW-1:0]            other_day;
  logic [gdr_pkg::MonthW-1:0]          other_month;
  logic [gdr_pkg::YearW-1:0]           other_year;

  modport source (output valid, opcode, month_delta, other_day, other_month, other_year,
                  input ready);
  modport sink   (input valid, opcode, month_delta, other_day, other_month, other_year,
                  output ready);
endinterface

interface gdr_out_if;
  logic                        valid;
  logic                        ready;
  logic [gdr_pkg::DayW-1:0]    cur_day;
  logic [gdr_pkg::MonthW-1:0]  cur_month;
  logic [gdr_pkg::YearW-1:0]   cur_year;
  logic                        later_or_same;
  logic                        range_error;

  modport source (output valid, cur_day, cur_month, cur_year, later_or_same, range_error,
                  input ready);
  modport sink   (input valid, cur_day, cur_month, cur_year, later_or_same, range_error,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gregorian_date_register.sv
// gregorian_date_register: top level of the calendar date register
//
// Holds one Gregorian date. Each item on in_i carries an opcode (next day,
// add months, compare only, load date), a signed month count and a compare
// date. Each accepted item gives exactly one item on out_o: the stored date
// after the operation, whether it is later than or equal to the compare
// date, and a range error flag when the year would leave 0..MAX_YEAR (the
// date is then kept).
// An accepted item sits in the input register; the operation is then done
// on it and its result is loaded into the result register, from which out_o
// delivers it. One item per cycle is sustained while out_o is not stalled:
// the whole operation is a single pass of logic from the input register
// through the state to the result register, with a constant multiply in
// each century test.
// Reset (rst_ni low) sets the date to 1 January 2000 and empties both
// registers. When out_o is stalled the result holds, the input register
// still takes one more item, and in_i.ready then drops until out_o moves.
`default_nettype none

module gregorian_date_register #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gdr_in_if.sink    in_i,
  gdr_out_if.source out_o
);
  import gdr_pkg::*;

  gdr_item_t item;
  logic      item_valid;
  logic      item_ready;

  // input register and delta split
  gdr_decode #(
    .MAX_YEAR (MAX_YEAR)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // date state and result register
  gdr_update #(
    .MAX_YEAR (MAX_YEAR)
  ) u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/gdr_decode.sv
// gdr_decode: input register, pre-splits the month delta and prepares a load
`default_nettype none

module gdr_decode #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  gdr_in_if.sink             in_i,
  output gdr_pkg::gdr_item_t item_o,
  output logic               item_valid_o,
  input  wire logic          item_ready_i
);
  import gdr_pkg::*;

  logic                 valid_q;
  gdr_item_t            item_q, item_d;
  logic [12:0]          dlt_off;
  logic [25:0]          dlt_prod;
  logic [9:0]           dlt_quot;
  logic [12:0]          dlt_rem;
  logic [MonthW-1:0]    ld_month;
  logic                 ld_leap;
  logic [DayW-1:0]      ld_len;
  logic [DayW-1:0]      ld_day;

  // input register frees up when empty or when its item moves on
  assign in_i.ready = !valid_q || item_ready_i;

  // floor split of the month delta by twelve
  always_comb begin
    dlt_off  = {in_i.month_delta[DeltaW-1], in_i.month_delta} + DeltaOffset;
    dlt_prod = 26'(dlt_off) * 26'(Recip12);
    dlt_quot = dlt_prod[Recip12Shift +: 10];
    dlt_rem  = dlt_off - 13'(dlt_quot) * 13'(MonthsPerYear);
  end

  // corrected date for a load
  always_comb begin
    if (in_i.other_month == '0) begin
      ld_month = MonthJan;
    end else if (in_i.other_month > MonthDec) begin
      ld_month = MonthDec;
    end else begin
      ld_month = in_i.other_month;
    end
    ld_leap = gdr_is_leap({1'b0, in_i.other_year});
    ld_len  = gdr_month_len(ld_month, ld_leap);
    if (in_i.other_day == '0) begin
      ld_day = ResetDay;
    end else if (in_i.other_day > ld_len) begin
      ld_day = ld_len;
    end else begin
      ld_day = in_i.other_day;
    end
  end

  // pack the decoded item
  always_comb begin
    item_d.op        = gdr_op_e'(in_i.opcode);
    item_d.dq        = $signed(dlt_quot) - $signed(DqW'(DeltaOffsetYears));
    item_d.dr        = dlt_rem[3:0];
    item_d.ld_day    = ld_day;
    item_d.ld_month  = ld_month;
    item_d.ld_leap   = ld_leap;
    item_d.ld_err    = (in_i.other_year > YearW'(MAX_YEAR));
    item_d.cmp_day   = in_i.other_day;
    item_d.cmp_month = in_i.other_month;
    item_d.cmp_year  = in_i.other_year;
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= item_d;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/gdr_update.sv
// gdr_update: date state, combinational operation and result register
`default_nettype none

module gdr_update #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  gdr_pkg::gdr_item_t item_i,
  input  wire logic          item_valid_i,
  output logic               item_ready_o,
  gdr_out_if.source          out_o
);
  import gdr_pkg::*;

  // stored date and leap flag of the stored year
  logic [DayW-1:0]          day_q, day_d;
  logic [MonthW-1:0]        month_q, month_d;
  logic [YearW-1:0]         year_q, year_d;
  logic                     leap_q, leap_d;
  logic                     err_d;
  logic                     later_d;

  // result register
  logic                     out_valid_q;
  logic [DayW-1:0]          res_day_q;
  logic [MonthW-1:0]        res_month_q;
  logic [YearW-1:0]         res_year_q;
  logic                     res_later_q;
  logic                     res_err_q;

  // next day
  logic [DayW-1:0]          nd_len;
  logic [DayW:0]            nd_inc;
  logic                     nd_roll;
  logic [DayW-1:0]          nd_day;
  logic [MonthW-1:0]        nd_month;
  logic [YearXW-1:0]        nd_year;
  logic                     nd_err;

  // add months
  logic [4:0]               am_sum;
  logic                     am_carry;
  logic [4:0]               am_mon0;
  logic signed [YearXW:0]   am_year;
  logic [MonthW-1:0]        am_month;
  logic                     am_err;
  logic                     am_leap;
  logic [DayW-1:0]          am_len;
  logic [DayW-1:0]          am_day;

  logic                     fire;

  assign item_ready_o = !out_valid_q || out_o.ready;
  assign fire         = item_valid_i && item_ready_o;

  // advance one day
  always_comb begin
    nd_len  = gdr_month_len(month_q, leap_q);
    nd_inc  = {1'b0, day_q} + 6'd1;
    nd_roll = (nd_inc > {1'b0, nd_len});
    nd_day  = nd_roll ? ResetDay : nd_inc[DayW-1:0];
    nd_month = month_q;
    nd_year  = {1'b0, year_q};
    if (nd_roll) begin
      if (month_q == MonthDec) begin
        nd_month = MonthJan;
        nd_year  = {1'b0, year_q} + YearXW'(1);
      end else begin
        nd_month = month_q + 4'd1;
      end
    end
    nd_err = (nd_year > YearXW'(MAX_YEAR));
  end

  // add a signed number of months
  always_comb begin
    am_sum   = 5'(month_q - MonthJan) + 5'(item_i.dr);
    am_carry = (am_sum >= 5'(MonthsPerYear));
    am_mon0  = am_carry ? am_sum - 5'(MonthsPerYear) : am_sum;
    am_month = am_mon0[MonthW-1:0] + MonthJan;
    am_year  = $signed({2'b00, year_q}) + (YearXW+1)'(item_i.dq)
               + $signed({(YearXW)'(0), am_carry});
    am_err   = am_year[YearXW] || (am_year > $signed((YearXW+1)'(MAX_YEAR)));
    am_leap  = gdr_is_leap(am_year[YearXW-1:0]);
    am_len   = gdr_month_len(am_month, am_leap);
    am_day   = (day_q > am_len) ? am_len : day_q;
  end

  // select the operation
  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    leap_d  = leap_q;
    err_d   = 1'b0;
    unique case (item_i.op)
      OP_NEXT_DAY: begin
        err_d = nd_err;
        if (!nd_err) begin
          day_d   = nd_day;
          month_d = nd_month;
          year_d  = nd_year[YearW-1:0];
          leap_d  = gdr_is_leap(nd_year);
        end
      end
      OP_ADD_MONTHS: begin
        err_d = am_err;
        if (!am_err) begin
          day_d   = am_day;
          month_d = am_month;
          year_d  = am_year[YearW-1:0];
          leap_d  = am_leap;
        end
      end
      OP_COMPARE: begin
        err_d = 1'b0;
      end
      OP_LOAD: begin
        err_d = item_i.ld_err;
        if (!item_i.ld_err) begin
          day_d   = item_i.ld_day;
          month_d = item_i.ld_month;
          year_d  = item_i.cmp_year;
          leap_d  = item_i.ld_leap;
        end
      end
      default: begin
        err_d = 1'b0;
      end
    endcase
  end

  // compare the new date with the compare date
  always_comb begin
    if (year_d != item_i.cmp_year) begin
      later_d = (year_d > item_i.cmp_year);
    end else if (month_d != item_i.cmp_month) begin
      later_d = (month_d > item_i.cmp_month);
    end else begin
      later_d = (day_d >= item_i.cmp_day);
    end
  end

  // control and date state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      day_q       <= ResetDay;
      month_q     <= ResetMonth;
      year_q      <= ResetYear;
      leap_q      <= ResetLeap;
    end else if (fire) begin
      out_valid_q <= 1'b1;
      day_q       <= day_d;
      month_q     <= month_d;
      year_q      <= year_d;
      leap_q      <= leap_d;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_day_q   <= day_d;
      res_month_q <= month_d;
      res_year_q  <= year_d;
      res_later_q <= later_d;
      res_err_q   <= err_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cur_day       = res_day_q;
  assign out_o.cur_month     = res_month_q;
  assign out_o.cur_year      = res_year_q;
  assign out_o.later_or_same = res_later_q;
  assign out_o.range_error   = res_err_q;

endmodule

`default_nettype wire

FILE: rtl/core/gdr_checker.sv
// gdr_checker: port-level checks of the date register, bound to the top level
`default_nettype none

module gdr_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [gdr_pkg::DayW-1:0]    out_day_i,
  input wire logic [gdr_pkg::MonthW-1:0]  out_month_i,
  input wire logic [gdr_pkg::YearW-1:0]   out_year_i,
  input wire logic                        out_later_i,
  input wire logic                        out_err_i
);
  import gdr_pkg::*;

  // date of the last delivered item, starting at the reset date
  logic [DayW-1:0]   prev_day_q;
  logic [MonthW-1:0] prev_month_q;
  logic [YearW-1:0]  prev_year_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_day_q   <= ResetDay;
      prev_month_q <= ResetMonth;
      prev_year_q  <= ResetYear;
    end else if (out_valid_i && out_ready_i) begin
      prev_day_q   <= out_day_i;
      prev_month_q <= out_month_i;
      prev_year_q  <= out_year_i;
    end
  end

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_day_i) &&
      $stable(out_month_i) && $stable(out_year_i) && $stable(out_later_i) &&
      $stable(out_err_i))
    else $error("stalled result changed");

  // with no pending result the block takes input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // a refused operation keeps the date
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_err_i |-> out_day_i == prev_day_q &&
      out_month_i == prev_month_q && out_year_i == prev_year_q)
    else $error("range error changed the date");

  // delivered dates are well formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_day_i != '0 && out_month_i != '0 && out_month_i <= MonthDec)
    else $error("malformed date");

  // nothing is delivered right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind gregorian_date_register gdr_checker u_gdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_day_i   (out_o.cur_day),
  .out_month_i (out_o.cur_month),
  .out_year_i  (out_o.cur_year),
  .out_later_i (out_o.later_or_same),
  .out_err_i   (out_o.range_error)
);

`default_nettype wire
